[hdl/bfa_pkg.sv]
package bfa_pkg;

   localparam int FLOWS       = 256;
   localparam int IDX_W       = $clog2(FLOWS);
   localparam int FILL_W      = $clog2(FLOWS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PROTO_TCP = 8'd6;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_FWD  = 3'd1,
      ST_REV  = 3'd2,
      ST_NEW  = 3'd3,
      ST_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
   } key_type;

   typedef struct packed {
      logic        is_tcp;
      key_type     key;
      logic [15:0] len;
      logic [62:0] ts;
      logic [31:0] pkt_num;
   } q_item_type;

   typedef struct packed {
      logic [31:0] packets;
      logic [47:0] bytes;
      logic [31:0] fwd_packets;
      logic [47:0] fwd_bytes;
      logic [31:0] rev_packets;
      logic [47:0] rev_bytes;
      logic [62:0] start_ts;
      logic [62:0] last_ts;
   } flow_rec_type;

   typedef struct packed {
      status_type   status;
      logic [7:0]   stream_index;
      logic [31:0]  packet_number;
      flow_rec_type rec;
   } rsp_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      logic [32:0] s;
      s = {1'b0, a} + 33'd1;
      return s[32] ? '1 : s[31:0];
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {33'd0, b};
      return s[48] ? '1 : s[47:0];
   endfunction

endpackage

[hdl/bfa_if.sv]
interface bfa_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  protocol;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] pkt_len;
   logic [62:0] ts_us;

   modport source (output valid, output protocol, output src_ip, output dst_ip,
                   output src_port, output dst_port, output pkt_len, output ts_us,
                   input ready);
   modport sink (input valid, input protocol, input src_ip, input dst_ip,
                 input src_port, input dst_port, input pkt_len, input ts_us,
                 output ready);
endinterface

interface bfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  stream_index;
   logic [31:0] packet_number;
   logic [31:0] flow_packets;
   logic [47:0] flow_bytes;
   logic [31:0] fwd_packets;
   logic [47:0] fwd_bytes;
   logic [31:0] rev_packets;
   logic [47:0] rev_bytes;
   logic [62:0] start_us;
   logic [62:0] end_us;

   modport source (output valid, output status, output stream_index, output packet_number,
                   output flow_packets, output flow_bytes, output fwd_packets,
                   output fwd_bytes, output rev_packets, output rev_bytes,
                   output start_us, output end_us, input ready);
   modport sink (input valid, input status, input stream_index, input packet_number,
                 input flow_packets, input flow_bytes, input fwd_packets,
                 input fwd_bytes, input rev_packets, input rev_bytes,
                 input start_us, input end_us, output ready);
endinterface

[hdl/bidirectional_flow_accounting_top.sv]
// channel | dir | transfer when      | payload
// req_ch  | in  | valid && ready     | protocol, ips, ports, pkt_len, ts_us
// rsp_ch  | out | valid && ready     | status, stream_index, counters, times
//
// N being the number of flows created so far, a TCP packet has its key compared
// with all N entries; a non-TCP packet skips the scan. The key scan reads one
// entry a cycle, then a hit does a counter read-modify-write. The back takes no
// new packet until the last one's result is in the result register.
// Reset clears the fill count and the packet number; no clearing pass.
// A two-entry queue lets the front keep taking packets while the back scans,
// and the result register frees the back while a result waits on rsp_ch.
module bidirectional_flow_accounting_top
   import bfa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bfa_req_if.sink   req_ch,
   bfa_rsp_if.source rsp_ch
);

   logic       push;
   logic       pop;
   logic       q_empty;
   logic       q_full;
   q_item_type push_item;
   q_item_type q_head;

   bfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   bfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   bfa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[hdl/bfa_front.sv]
module bfa_front
   import bfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bfa_req_if.sink    req_ch,
   input  logic       q_full,
   output logic       push,
   output q_item_type push_item
);

   logic [31:0] pkt_cnt_ff;
   logic [31:0] pkt_cnt_in;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      push_item.is_tcp    = (req_ch.protocol == PROTO_TCP);
      push_item.key.sip   = req_ch.src_ip;
      push_item.key.dip   = req_ch.dst_ip;
      push_item.key.sport = req_ch.src_port;
      push_item.key.dport = req_ch.dst_port;
      push_item.len       = req_ch.pkt_len;
      push_item.ts        = req_ch.ts_us;
      // every packet is numbered, tracked or not
      push_item.pkt_num   = sat_inc32(pkt_cnt_ff);
   end

   assign pkt_cnt_in = push ? push_item.pkt_num : pkt_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_cnt_ff <= '0;
      end else begin
         pkt_cnt_ff <= pkt_cnt_in;
      end
   end

endmodule

[hdl/bfa_queue.sv]
module bfa_queue
   import bfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   input  logic       pop,
   output logic       empty,
   output logic       full,
   output q_item_type head
);

   q_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/bfa_back.sv]
module bfa_back
   import bfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  q_item_type q_head,
   output logic       q_pop,
   bfa_rsp_if.source  rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_UPDATE,
      S_EMIT
   } state_type;

   key_type      key_mem  [FLOWS];
   flow_rec_type data_mem [FLOWS];

   state_type         state_ff, state_in;
   q_item_type        cur_ff, cur_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [IDX_W-1:0]  fwd_idx_ff, fwd_idx_in;
   logic              rev_hit_ff, rev_hit_in;
   logic [IDX_W-1:0]  rev_idx_ff, rev_idx_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   status_type        status_ff, status_in;
   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff, out_in;

   key_type           key_rd_ff;
   flow_rec_type      data_rd_ff;

   logic              key_we;
   logic              data_we;
   logic [IDX_W-1:0]  data_wr_addr;
   flow_rec_type      data_wr;

   logic              out_free;
   key_type           rev_key;
   flow_rec_type      rec_upd;
   flow_rec_type      rec_new;

   assign out_free = !out_vld_ff || rsp_ch.ready;

   always_comb begin
      rev_key.sip   = cur_ff.key.dip;
      rev_key.dip   = cur_ff.key.sip;
      rev_key.sport = cur_ff.key.dport;
      rev_key.dport = cur_ff.key.sport;
   end

   always_comb begin
      rec_upd          = data_rd_ff;
      rec_upd.packets  = sat_inc32(data_rd_ff.packets);
      rec_upd.bytes    = sat_add48(data_rd_ff.bytes, cur_ff.len);
      rec_upd.last_ts  = cur_ff.ts;
      if (status_ff == ST_FWD) begin
         rec_upd.fwd_packets = sat_inc32(data_rd_ff.fwd_packets);
         rec_upd.fwd_bytes   = sat_add48(data_rd_ff.fwd_bytes, cur_ff.len);
      end else begin
         rec_upd.rev_packets = sat_inc32(data_rd_ff.rev_packets);
         rec_upd.rev_bytes   = sat_add48(data_rd_ff.rev_bytes, cur_ff.len);
      end
   end

   always_comb begin
      rec_new.packets     = 32'd1;
      rec_new.bytes       = {32'd0, cur_ff.len};
      rec_new.fwd_packets = 32'd1;
      rec_new.fwd_bytes   = {32'd0, cur_ff.len};
      rec_new.rev_packets = '0;
      rec_new.rev_bytes   = '0;
      rec_new.start_ts    = cur_ff.ts;
      rec_new.last_ts     = cur_ff.ts;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_idx_in   = fwd_idx_ff;
      rev_hit_in   = rev_hit_ff;
      rev_idx_in   = rev_idx_ff;
      hit_idx_in   = hit_idx_ff;
      status_in    = status_ff;
      out_vld_in   = out_vld_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;
      key_we       = 1'b0;
      data_we      = 1'b0;
      data_wr_addr = hit_idx_ff;
      data_wr      = rec_upd;

      if (out_vld_ff && rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               cur_in     = q_head;
               scan_in    = '0;
               fwd_hit_in = 1'b0;
               rev_hit_in = 1'b0;
               if (q_head.is_tcp) begin
                  state_in = S_SCAN;
               end else begin
                  status_in = ST_NONE;
                  state_in  = S_EMIT;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff < fill_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               // keep the lowest index in each direction
               if (key_rd_ff == cur_ff.key && !fwd_hit_ff) begin
                  fwd_hit_in = 1'b1;
                  fwd_idx_in = cmp_idx_ff;
               end
               if (key_rd_ff == rev_key && !rev_hit_ff) begin
                  rev_hit_in = 1'b1;
                  rev_idx_in = cmp_idx_ff;
               end
            end else if (scan_ff == fill_ff) begin
               priority if (fwd_hit_ff) begin
                  hit_idx_in = fwd_idx_ff;
                  status_in  = ST_FWD;
                  state_in   = S_FETCH;
               end else if (rev_hit_ff) begin
                  hit_idx_in = rev_idx_ff;
                  status_in  = ST_REV;
                  state_in   = S_FETCH;
               end else if (fill_ff == FILL_W'(FLOWS)) begin
                  status_in = ST_FULL;
                  state_in  = S_EMIT;
               end else begin
                  status_in = ST_NEW;
                  state_in  = S_EMIT;
               end
            end
         end
         S_FETCH: begin
            // counter record read is in flight
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               data_we                 = 1'b1;
               out_vld_in              = 1'b1;
               out_in.status           = status_ff;
               out_in.stream_index     = 8'(hit_idx_ff);
               out_in.packet_number    = cur_ff.pkt_num;
               out_in.rec              = rec_upd;
               state_in                = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_vld_in           = 1'b1;
               out_in.status        = status_ff;
               out_in.packet_number = cur_ff.pkt_num;
               if (status_ff == ST_NEW) begin
                  key_we              = 1'b1;
                  data_we             = 1'b1;
                  data_wr_addr        = fill_ff[IDX_W-1:0];
                  data_wr             = rec_new;
                  out_in.stream_index = 8'(fill_ff[IDX_W-1:0]);
                  out_in.rec          = rec_new;
                  fill_in             = fill_ff + 1'b1;
               end else begin
                  out_in.stream_index = '0;
                  out_in.rec          = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[scan_ff[IDX_W-1:0]];
      if (key_we) begin
         key_mem[fill_ff[IDX_W-1:0]] <= cur_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      data_rd_ff <= data_mem[hit_idx_ff];
      if (data_we) begin
         data_mem[data_wr_addr] <= data_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         rev_hit_ff <= 1'b0;
         status_ff  <= ST_NONE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
         fwd_hit_ff <= fwd_hit_in;
         rev_hit_ff <= rev_hit_in;
         status_ff  <= status_in;
         out_vld_ff <= out_vld_in;
      end
      cur_ff     <= cur_in;
      cmp_idx_ff <= cmp_idx_in;
      fwd_idx_ff <= fwd_idx_in;
      rev_idx_ff <= rev_idx_in;
      hit_idx_ff <= hit_idx_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.stream_index  = out_ff.stream_index;
   assign rsp_ch.packet_number = out_ff.packet_number;
   assign rsp_ch.flow_packets  = out_ff.rec.packets;
   assign rsp_ch.flow_bytes    = out_ff.rec.bytes;
   assign rsp_ch.fwd_packets   = out_ff.rec.fwd_packets;
   assign rsp_ch.fwd_bytes     = out_ff.rec.fwd_bytes;
   assign rsp_ch.rev_packets   = out_ff.rec.rev_packets;
   assign rsp_ch.rev_bytes     = out_ff.rec.rev_bytes;
   assign rsp_ch.start_us      = out_ff.rec.start_ts;
   assign rsp_ch.end_us        = out_ff.rec.last_ts;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FLOWS))
      else $error("flow fill count beyond table size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= fill_ff))
      else $error("key scan ran past filled entries");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_FULL) |-> (fill_ff == FILL_W'(FLOWS)))
      else $error("table full reported with free entries");

   a_hit_in_filled: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_FWD || rsp_ch.status == ST_REV))
      |-> (FILL_W'(rsp_ch.stream_index) < fill_ff))
      else $error("hit on an entry never filled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule
